/* rtl/rdd_pkg.sv */
// Shared types and constants for the Rice delta decoder.
`timescale 1ns / 1ps

package rdd_pkg;

    localparam int DATA_W    = 8;
    localparam int VALUE_W   = 64;
    localparam int NARROW_W  = 32;
    localparam int COUNT_W   = 32;
    localparam int K_W       = 6;
    localparam int CFG_IDX_W = 2;
    localparam int BIT_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RICE_PARAM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_BIT,
        ST_SHIFT,
        ST_ADD_Q,
        ST_ADD_R,
        ST_FLUSH,
        ST_UNDER,
        ST_END
    } t_state;

    typedef enum logic [1:0] {
        PH_QUOT,
        PH_REM,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_FIRST,
        ALU_SHIFT,
        ALU_ADD_Q,
        ALU_ADD_R
    } t_alu_op;

    // result request from the sequencer to the output stage
    typedef struct packed {
        logic push;    // new result enters the holding slot
        logic status;  // underflow
        logic done;    // last result of the decode
        logic flush;   // byte finished: holding slot goes out with run_end
    } t_emit;

endpackage

/* rtl/rdd_alu.sv */
// Shared shift/add unit holding the running value.
`timescale 1ns / 1ps

module rdd_alu (
    input  logic                              i_clk,
    input  rdd_pkg::t_alu_op                  i_op,
    input  logic [rdd_pkg::K_W-1:0]           i_rice_param,
    input  logic [rdd_pkg::VALUE_W-1:0]       i_first_value,
    input  logic                              i_wide_mode,
    input  logic [rdd_pkg::COUNT_W-1:0]       i_quotient,
    input  logic [rdd_pkg::VALUE_W-1:0]       i_remainder,
    output logic [rdd_pkg::VALUE_W-1:0]       o_next_value
);

    logic [rdd_pkg::VALUE_W-1:0] r_value;
    logic [rdd_pkg::VALUE_W-1:0] n_value;
    logic [rdd_pkg::VALUE_W-1:0] r_delta;
    logic [rdd_pkg::VALUE_W-1:0] n_delta;
    logic [rdd_pkg::VALUE_W-1:0] mask;
    logic [rdd_pkg::VALUE_W-1:0] add_b;
    logic [rdd_pkg::VALUE_W-1:0] sum;

    assign mask = {{(rdd_pkg::VALUE_W - rdd_pkg::NARROW_W){i_wide_mode}},
                   {rdd_pkg::NARROW_W{1'b1}}};

    // one adder, second operand is either the shifted quotient or the remainder
    assign add_b = (i_op == rdd_pkg::ALU_ADD_Q) ? r_delta : i_remainder;
    assign sum   = r_value + add_b;

    always_comb begin
        n_value = r_value;
        n_delta = r_delta;
        case (i_op)
            rdd_pkg::ALU_FIRST: n_value = i_first_value & mask;
            rdd_pkg::ALU_SHIFT: n_delta = rdd_pkg::VALUE_W'(i_quotient) << i_rice_param;
            rdd_pkg::ALU_ADD_Q: n_value = sum & mask;
            rdd_pkg::ALU_ADD_R: n_value = sum & mask;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_delta <= n_delta;
    end

    assign o_next_value = n_value;

endmodule

/* rtl/rdd_out.sv */
// Holding slot and output register; the last result of a byte leaves with run_end.
`timescale 1ns / 1ps

module rdd_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rdd_pkg::t_emit                    i_emit,
    input  logic [rdd_pkg::VALUE_W-1:0]       i_value,
    input  logic                              i_out_ready,
    output logic                              o_room,
    output logic                              o_pend_valid,
    output logic                              o_out_valid,
    output logic [rdd_pkg::VALUE_W-1:0]       o_value,
    output logic                              o_status,
    output logic                              o_stream_done,
    output logic                              o_run_end
);

    logic                          r_pend_valid;
    logic [rdd_pkg::VALUE_W-1:0]   r_pend_value;
    logic                          r_pend_status;
    logic                          r_pend_done;
    logic                          r_out_valid;
    logic [rdd_pkg::VALUE_W-1:0]   r_out_value;
    logic                          r_out_status;
    logic                          r_out_done;
    logic                          r_out_run_end;
    logic                          move;

    // sequencer only pushes or flushes when o_room is high
    assign o_room = !r_pend_valid || !r_out_valid || i_out_ready;
    assign move   = r_pend_valid && (i_emit.push || i_emit.flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_emit.push) begin
                r_pend_valid <= 1'b1;
            end else if (i_emit.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.push) begin
            r_pend_value  <= i_emit.status ? '0 : i_value;
            r_pend_status <= i_emit.status;
            r_pend_done   <= i_emit.done;
        end
        if (move) begin
            r_out_value   <= r_pend_value;
            r_out_status  <= r_pend_status;
            r_out_done    <= r_pend_done;
            r_out_run_end <= i_emit.flush;
        end
    end

    assign o_pend_valid  = r_pend_valid;
    assign o_out_valid   = r_out_valid;
    assign o_value       = r_out_value;
    assign o_status      = r_out_status;
    assign o_stream_done = r_out_done;
    assign o_run_end     = r_out_run_end;

endmodule

/* rtl/rdd_ctrl.sv */
// Bit-serial sequencer: walks the byte, tracks codes and issues unit ops and results.
`timescale 1ns / 1ps

module rdd_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic [rdd_pkg::DATA_W-1:0]        i_data_byte,
    input  logic                              i_final_byte,
    input  logic [rdd_pkg::K_W-1:0]           i_rice_param,
    input  logic [rdd_pkg::COUNT_W-1:0]       i_entry_count,
    input  logic                              i_room,
    output logic                              o_in_ready,
    output rdd_pkg::t_alu_op                  o_alu_op,
    output logic [rdd_pkg::COUNT_W-1:0]       o_quotient,
    output logic [rdd_pkg::VALUE_W-1:0]       o_remainder,
    output rdd_pkg::t_emit                    o_emit
);

    rdd_pkg::t_state                  r_state, n_state;
    rdd_pkg::t_phase                  r_phase, n_phase;
    logic                             r_first_sent, n_first_sent;
    logic [rdd_pkg::COUNT_W-1:0]      r_quot, n_quot;
    logic [rdd_pkg::VALUE_W-1:0]      r_rem, n_rem;
    logic [rdd_pkg::K_W-1:0]          r_ridx, n_ridx;
    logic [rdd_pkg::COUNT_W-1:0]      r_entries, n_entries;
    logic [rdd_pkg::DATA_W-1:0]       r_byte, n_byte;
    logic                             r_last, n_last;
    logic [rdd_pkg::BIT_IDX_W-1:0]    r_bit_idx, n_bit_idx;
    logic                             r_in_flush, n_in_flush;

    logic                             accept;
    logic                             cur_bit;
    logic                             last_bit;
    logic [rdd_pkg::K_W:0]            ridx_inc;
    logic                             rem_full;
    logic                             k_zero;
    logic [rdd_pkg::COUNT_W-1:0]      entries_inc;
    logic                             code_last;
    logic                             first_last;

    assign accept      = i_in_valid && (r_state == rdd_pkg::ST_IDLE);
    assign cur_bit     = r_byte[r_bit_idx];
    assign last_bit    = &r_bit_idx;
    assign ridx_inc    = {1'b0, r_ridx} + (rdd_pkg::K_W+1)'(1);
    assign rem_full    = ridx_inc >= {1'b0, i_rice_param};
    assign k_zero      = (i_rice_param == '0);
    assign entries_inc = r_entries + rdd_pkg::COUNT_W'(1);
    assign code_last   = entries_inc >= i_entry_count;
    assign first_last  = r_entries >= i_entry_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rdd_pkg::ST_IDLE: begin
                if (accept && r_phase != rdd_pkg::PH_DONE) begin
                    n_state = r_first_sent ? rdd_pkg::ST_BIT : rdd_pkg::ST_FIRST;
                end
            end
            rdd_pkg::ST_FIRST: begin
                if (i_room) begin
                    n_state = first_last ? rdd_pkg::ST_END : rdd_pkg::ST_BIT;
                end
            end
            rdd_pkg::ST_BIT: begin
                if (r_phase == rdd_pkg::PH_DONE) begin
                    n_state = rdd_pkg::ST_END;
                end else if (r_phase == rdd_pkg::PH_QUOT && !cur_bit && k_zero) begin
                    n_state = rdd_pkg::ST_SHIFT;
                end else if (r_phase == rdd_pkg::PH_REM && rem_full) begin
                    n_state = rdd_pkg::ST_SHIFT;
                end else if (last_bit) begin
                    n_state = rdd_pkg::ST_FLUSH;
                end
            end
            rdd_pkg::ST_SHIFT: n_state = rdd_pkg::ST_ADD_Q;
            rdd_pkg::ST_ADD_Q: n_state = rdd_pkg::ST_ADD_R;
            rdd_pkg::ST_ADD_R: begin
                if (i_room) begin
                    n_state = (r_in_flush || last_bit) ? rdd_pkg::ST_FLUSH : rdd_pkg::ST_BIT;
                end
            end
            rdd_pkg::ST_FLUSH: begin
                if (!r_last || r_phase == rdd_pkg::PH_DONE) begin
                    n_state = rdd_pkg::ST_END;
                end else if (r_phase == rdd_pkg::PH_REM) begin
                    n_state = rdd_pkg::ST_SHIFT;
                end else begin
                    n_state = rdd_pkg::ST_UNDER;
                end
            end
            rdd_pkg::ST_UNDER: begin
                if (i_room) begin
                    n_state = rdd_pkg::ST_END;
                end
            end
            rdd_pkg::ST_END: begin
                if (i_room) begin
                    n_state = rdd_pkg::ST_IDLE;
                end
            end
            default: n_state = rdd_pkg::ST_IDLE;
        endcase
    end

    // outputs and code state
    always_comb begin
        n_phase      = r_phase;
        n_first_sent = r_first_sent;
        n_quot       = r_quot;
        n_rem        = r_rem;
        n_ridx       = r_ridx;
        n_entries    = r_entries;
        n_byte       = r_byte;
        n_last       = r_last;
        n_bit_idx    = r_bit_idx;
        n_in_flush   = r_in_flush;
        o_alu_op     = rdd_pkg::ALU_NOP;
        o_emit       = '0;
        case (r_state)
            rdd_pkg::ST_IDLE: begin
                if (accept) begin
                    n_byte     = i_data_byte;
                    n_last     = i_final_byte;
                    n_bit_idx  = '0;
                    n_in_flush = 1'b0;
                end
            end
            rdd_pkg::ST_FIRST: begin
                if (i_room) begin
                    o_alu_op     = rdd_pkg::ALU_FIRST;
                    o_emit.push  = 1'b1;
                    o_emit.done  = first_last;
                    n_first_sent = 1'b1;
                    if (first_last) begin
                        n_phase = rdd_pkg::PH_DONE;
                    end
                end
            end
            rdd_pkg::ST_BIT: begin
                if (r_phase == rdd_pkg::PH_QUOT) begin
                    if (cur_bit) begin
                        n_quot    = r_quot + rdd_pkg::COUNT_W'(1);
                        n_bit_idx = r_bit_idx + rdd_pkg::BIT_IDX_W'(1);
                    end else if (!k_zero) begin
                        n_phase   = rdd_pkg::PH_REM;
                        n_rem     = '0;
                        n_ridx    = '0;
                        n_bit_idx = r_bit_idx + rdd_pkg::BIT_IDX_W'(1);
                    end
                end else if (r_phase == rdd_pkg::PH_REM) begin
                    n_rem  = r_rem | (rdd_pkg::VALUE_W'(cur_bit) << r_ridx);
                    n_ridx = ridx_inc[rdd_pkg::K_W-1:0];
                    if (!rem_full) begin
                        n_bit_idx = r_bit_idx + rdd_pkg::BIT_IDX_W'(1);
                    end
                end
            end
            rdd_pkg::ST_SHIFT: o_alu_op = rdd_pkg::ALU_SHIFT;
            rdd_pkg::ST_ADD_Q: o_alu_op = rdd_pkg::ALU_ADD_Q;
            rdd_pkg::ST_ADD_R: begin
                if (i_room) begin
                    o_alu_op    = rdd_pkg::ALU_ADD_R;
                    o_emit.push = 1'b1;
                    o_emit.done = code_last;
                    n_entries   = entries_inc;
                    n_quot      = '0;
                    n_rem       = '0;
                    n_ridx      = '0;
                    n_phase     = code_last ? rdd_pkg::PH_DONE : rdd_pkg::PH_QUOT;
                    if (!r_in_flush) begin
                        n_bit_idx = r_bit_idx + rdd_pkg::BIT_IDX_W'(1);
                    end
                end
            end
            rdd_pkg::ST_FLUSH: begin
                if (r_last && r_phase == rdd_pkg::PH_REM) begin
                    n_in_flush = 1'b1;
                end
            end
            rdd_pkg::ST_UNDER: begin
                if (i_room) begin
                    o_emit.push   = 1'b1;
                    o_emit.status = 1'b1;
                    o_emit.done   = 1'b1;
                    n_phase       = rdd_pkg::PH_DONE;
                end
            end
            rdd_pkg::ST_END: begin
                if (i_room) begin
                    o_emit.flush = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rdd_pkg::ST_IDLE;
            r_phase      <= rdd_pkg::PH_QUOT;
            r_first_sent <= 1'b0;
            r_quot       <= '0;
            r_rem        <= '0;
            r_ridx       <= '0;
            r_entries    <= '0;
            r_bit_idx    <= '0;
            r_in_flush   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_first_sent <= n_first_sent;
            r_quot       <= n_quot;
            r_rem        <= n_rem;
            r_ridx       <= n_ridx;
            r_entries    <= n_entries;
            r_bit_idx    <= n_bit_idx;
            r_in_flush   <= n_in_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_in_ready  = (r_state == rdd_pkg::ST_IDLE);
    assign o_quotient  = r_quot;
    assign o_remainder = r_rem;

endmodule

/* rtl/rice_delta_decoder.sv */
// Top level of the streaming Rice/Golomb delta decoder.
`timescale 1ns / 1ps

// Rice delta decoder. Takes one encoded byte per item, bits used LSB first.
// Each code is a unary quotient (run of 1s closed by a 0) and rice_param
// remainder bits, LSB first; the delta (q << k) + r is added to a running
// value that wraps at 32 bits (wide_mode 0) or 64 bits (wide_mode 1). The
// first result of a stream is first_value; after entry_count deltas the
// decode is done and further bytes produce nothing until reset. A final
// byte that ends inside a remainder zero-pads it and emits the value; a
// final byte with deltas still missing adds an underflow result (status 1,
// value 0, stream_done 1). run_end marks the last result of each byte.
// A sequencer consumes one bit per cycle, pausing while a code is added in
// or the output side stalls, and routes every decoded value through one
// shared shifter/adder (shift, add quotient part, add remainder). A byte
// passes through the bit steps, a flush step, an end step and the idle
// state that takes the next byte; each code completed inside the byte adds
// the shift and add steps, a remainder padded out at the final byte adds
// them and a second flush, and the first value and an underflow result add
// a step each. Once the decode completes, the rest of that byte is skipped,
// and every later byte is taken in the idle state and gives no result.
// in_ready is low the whole time a byte is worked on. Results leave
// through a holding slot and an output register, so one finished result
// may wait downstream while decoding continues. Configuration writes are
// taken at once, with no handshake, and should only be made between bytes.

module rice_delta_decoder (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // encoded byte channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [rdd_pkg::DATA_W-1:0]            i_data_byte,
    input  logic                                  i_final_byte,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [rdd_pkg::VALUE_W-1:0]           o_value,
    output logic                                  o_status,
    output logic                                  o_stream_done,
    output logic                                  o_run_end,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [rdd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rdd_pkg::VALUE_W-1:0]           i_cfg_wdata
);

    logic [rdd_pkg::K_W-1:0]      r_rice_param;
    logic [rdd_pkg::VALUE_W-1:0]  r_first_value;
    logic [rdd_pkg::COUNT_W-1:0]  r_entry_count;
    logic                         r_wide_mode;

    rdd_pkg::t_alu_op             alu_op;
    rdd_pkg::t_emit               emit;
    logic [rdd_pkg::COUNT_W-1:0]  quotient;
    logic [rdd_pkg::VALUE_W-1:0]  remainder;
    logic [rdd_pkg::VALUE_W-1:0]  next_value;
    logic                         room;
    logic                         pend_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rice_param  <= '0;
            r_first_value <= '0;
            r_entry_count <= '0;
            r_wide_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rdd_pkg::CFG_RICE_PARAM:  r_rice_param  <= i_cfg_wdata[rdd_pkg::K_W-1:0];
                rdd_pkg::CFG_FIRST_VALUE: r_first_value <= i_cfg_wdata;
                rdd_pkg::CFG_ENTRY_COUNT: r_entry_count <= i_cfg_wdata[rdd_pkg::COUNT_W-1:0];
                rdd_pkg::CFG_WIDE_MODE:   r_wide_mode   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    rdd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .i_rice_param  (r_rice_param),
        .i_entry_count (r_entry_count),
        .i_room        (room),
        .o_in_ready    (o_in_ready),
        .o_alu_op      (alu_op),
        .o_quotient    (quotient),
        .o_remainder   (remainder),
        .o_emit        (emit)
    );

    // shared shift/add unit; keeps the running value
    rdd_alu u_alu (
        .i_clk         (i_clk),
        .i_op          (alu_op),
        .i_rice_param  (r_rice_param),
        .i_first_value (r_first_value),
        .i_wide_mode   (r_wide_mode),
        .i_quotient    (quotient),
        .i_remainder   (remainder),
        .o_next_value  (next_value)
    );

    // a result is held in a slot so run_end can be set once the byte ends
    rdd_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_emit        (emit),
        .i_value       (next_value),
        .i_out_ready   (i_out_ready),
        .o_room        (room),
        .o_pend_valid  (pend_valid),
        .o_out_valid   (o_out_valid),
        .o_value       (o_value),
        .o_status      (o_status),
        .o_stream_done (o_stream_done),
        .o_run_end     (o_run_end)
    );

`ifndef ASSERT_OFF
    // an underflow result is always the last one, for the byte and the decode
    a_underflow_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_value == '0 && o_stream_done && o_run_end)
        else $error("underflow result malformed");

    // nothing may follow the final result of a decode
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_stream_done |=> !o_out_valid)
        else $error("result after stream_done");

    // a new byte is taken only once the previous byte's results have left the slot
    a_idle_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !pend_valid)
        else $error("byte accepted with result still held");
`endif

endmodule

/* test/rdd_checker.sv */
// Result checker for the Rice delta decoder: decodes each accepted byte and compares the results.
`timescale 1ns / 1ps

module rdd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [rdd_pkg::DATA_W-1:0]    i_data_byte,
    input  logic                          i_final_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [rdd_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_status,
    input  logic                          i_stream_done,
    input  logic                          i_run_end,
    input  logic                          i_cfg_we,
    input  logic [rdd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rdd_pkg::VALUE_W-1:0]   i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending
);

    import rdd_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               status;
        logic               stream_done;
        logic               run_end;
    } t_decoded;

    // register copies
    logic [K_W-1:0]     rice_k;
    logic [VALUE_W-1:0] start_value;
    logic [COUNT_W-1:0] entry_limit;
    logic               wide;

    // decoder state
    t_phase             phase;
    logic               first_out;
    logic [COUNT_W-1:0] quot;
    logic [VALUE_W-1:0] rem_bits;
    int                 rem_idx;
    logic [VALUE_W-1:0] run_sum;
    logic [COUNT_W-1:0] entries;

    // last result of the byte is held back so run_end can be set on it
    t_decoded           held;
    logic               have_held;
    t_decoded           decoded_q[$];
    int                 fails;

    function automatic logic [VALUE_W-1:0] width_mask();
        return wide ? {VALUE_W{1'b1}} : {{(VALUE_W-NARROW_W){1'b0}}, {NARROW_W{1'b1}}};
    endfunction

    task automatic emit(input logic [VALUE_W-1:0] v, input logic st, input logic done);
        if (have_held)
            decoded_q.push_back(held);
        held      = '{value: v, status: st, stream_done: done, run_end: 1'b0};
        have_held = 1'b1;
    endtask

    task automatic close_code();
        logic [VALUE_W-1:0] delta;
        delta    = ({{(VALUE_W-COUNT_W){1'b0}}, quot} << rice_k) + rem_bits;
        run_sum  = (run_sum + delta) & width_mask();
        entries  = entries + 1'b1;
        quot     = '0;
        rem_bits = '0;
        rem_idx  = 0;
        phase    = (entries >= entry_limit) ? PH_DONE : PH_QUOT;
        emit(run_sum, 1'b0, phase == PH_DONE);
    endtask

    task automatic decode_byte(input logic [DATA_W-1:0] byte_in, input logic last);
        logic cur_bit;
        if (phase == PH_DONE)
            return;
        if (!first_out) begin
            first_out = 1'b1;
            run_sum   = start_value & width_mask();
            if (entries >= entry_limit)
                phase = PH_DONE;
            emit(run_sum, 1'b0, phase == PH_DONE);
        end
        for (int i = 0; i < DATA_W; i++) begin
            if (phase == PH_DONE)
                break;
            cur_bit = byte_in[i];
            if (phase == PH_QUOT) begin
                if (cur_bit) begin
                    quot = quot + 1'b1;
                end else if (rice_k == 0) begin
                    close_code();
                end else begin
                    phase    = PH_REM;
                    rem_bits = '0;
                    rem_idx  = 0;
                end
            end else begin
                rem_bits = rem_bits | ({{(VALUE_W-1){1'b0}}, cur_bit} << rem_idx);
                rem_idx++;
                if (rem_idx >= rice_k)
                    close_code();
            end
        end
        // end of stream: pad a partial remainder, then flag missing deltas
        if (last && phase != PH_DONE) begin
            if (phase == PH_REM)
                close_code();
            if (phase != PH_DONE) begin
                emit('0, 1'b1, 1'b1);
                phase = PH_DONE;
            end
        end
        if (have_held) begin
            held.run_end = 1'b1;
            decoded_q.push_back(held);
            have_held = 1'b0;
        end
    endtask

    task automatic check_result();
        t_decoded want;
        if (decoded_q.size() == 0) begin
            $error("unexpected result: value %h status %b", i_value, i_status);
            fails++;
            return;
        end
        want = decoded_q.pop_front();
        if (i_value !== want.value) begin
            $error("value: expected %h, got %h", want.value, i_value);
            fails++;
        end
        if (i_status !== want.status) begin
            $error("status: expected %b, got %b", want.status, i_status);
            fails++;
        end
        if (i_stream_done !== want.stream_done) begin
            $error("stream_done: expected %b, got %b", want.stream_done, i_stream_done);
            fails++;
        end
        if (i_run_end !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, i_run_end);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rice_k      = '0;
            start_value = '0;
            entry_limit = '0;
            wide        = 1'b0;
            phase       = PH_QUOT;
            first_out   = 1'b0;
            quot        = '0;
            rem_bits    = '0;
            rem_idx     = 0;
            run_sum     = '0;
            entries     = '0;
            have_held   = 1'b0;
            decoded_q.delete();
            fails       = 0;
        end else begin
            // results leave first: a byte taken at this edge cannot have one out yet
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RICE_PARAM:  rice_k      = i_cfg_wdata[K_W-1:0];
                    CFG_FIRST_VALUE: start_value = i_cfg_wdata;
                    CFG_ENTRY_COUNT: entry_limit = i_cfg_wdata[COUNT_W-1:0];
                    CFG_WIDE_MODE:   wide        = i_cfg_wdata[0];
                    default:         ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                decode_byte(i_data_byte, i_final_byte);
        end
        o_pending    <= decoded_q.size();
        o_fail_count <= fails;
    end

endmodule

/* test/tb_rice_delta_decoder.sv */
// Testbench top for the Rice delta decoder: stimulus, idling and the final verdict.
`timescale 1ns / 1ps

// One decode stream runs for the whole test, since only reset restarts it.
// Registers are rewritten between phases while the stream is still open, so
// codes that straddle a phase boundary see the new settings. The last phase
// ends the stream either by cutting entry_count to zero or by a final byte.

module tb_rice_delta_decoder;

    import rdd_pkg::*;

    localparam int SETTLE_CYCLES = 40;   // covers a byte that ends in no result
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 50;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [DATA_W-1:0]    data_byte;
    logic                 final_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [VALUE_W-1:0]   value;
    logic                 status;
    logic                 stream_done;
    logic                 run_end;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VALUE_W-1:0]   cfg_wdata;
    int                   fail_count;
    int                   pending;
    bit                   steady;        // no idling on either side while set

    rice_delta_decoder DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_data_byte   (data_byte),
        .i_final_byte  (final_byte),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_value       (value),
        .o_status      (status),
        .o_stream_done (stream_done),
        .o_run_end     (run_end),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata)
    );

    rdd_checker decode_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_data_byte   (data_byte),
        .i_final_byte  (final_byte),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_value       (value),
        .i_status      (status),
        .i_stream_done (stream_done),
        .i_run_end     (run_end),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 4 ns clock
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Register write: one cycle of write enable, then the enable is dropped.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [K_W-1:0] k, input logic [VALUE_W-1:0] first,
                              input logic [COUNT_W-1:0] count, input logic wide);
        write_reg(CFG_RICE_PARAM, VALUE_W'(k));
        write_reg(CFG_FIRST_VALUE, first);
        write_reg(CFG_ENTRY_COUNT, VALUE_W'(count));
        write_reg(CFG_WIDE_MODE, VALUE_W'(wide));
    endtask

    // Offer one byte after a random gap; returns just after the accepting edge.
    // With no gap, valid simply stays high into the next item.
    task automatic send_byte(input logic [DATA_W-1:0] b, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        final_byte <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending, wait for every predicted result, then let any trailing
    // bit work of the last byte finish before touching the registers.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: a fresh random stall before each item.
    initial begin : result_sink
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial begin : stimulus
        logic [K_W-1:0]     k;
        logic [COUNT_W-1:0] count;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = '0;
        final_byte = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_RICE_PARAM;
        cfg_wdata  = '0;
        steady     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // k = 3, narrow sums: the all-ones first value is cut to 32 bits
        set_config(3, {VALUE_W{1'b1}}, {COUNT_W{1'b1}}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);     // pure quotient run
        send_byte(8'hF0, 1'b0);
        send_byte(8'hCC, 1'b0);
        send_byte(8'hAA, 1'b0);
        wait_drained();

        // k = 0: every zero bit closes a code, up to eight results per byte
        set_config(0, '0, {COUNT_W{1'b1}}, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        wait_drained();

        // k = 63, wide sums: q << 63 drops its upper bits, remainder spans bytes
        steady = 1'b1;
        set_config(63, 64'h8000_0000_0000_0001, {COUNT_W{1'b1}}, 1'b1);
        send_byte(8'h03, 1'b0);
        repeat (8) send_byte(8'hFF, 1'b0);
        send_byte(8'h7E, 1'b0);
        wait_drained();
        steady = 1'b0;

        // random phases; codes left open carry into the next setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0:       k = 0;
                1:       k = 63;
                2:       k = K_W'($urandom_range(0, 63));
                default: k = K_W'($urandom_range(1, 6));
            endcase
            count = $urandom_range(0, 1) ? {COUNT_W{1'b1}}
                                         : $urandom_range(32'h0010_0000, 32'hFFFF_FFFE);
            set_config(k, {$urandom, $urandom}, count, 1'($urandom_range(0, 1)));
            repeat (PHASE_ITEMS) send_byte(DATA_W'($urandom_range(0, 255)), 1'b0);
            wait_drained();
        end

        // close the stream
        steady = 1'b0;
        if ($urandom_range(0, 1)) begin
            // entry_count below the codes already done: the next code ends it
            write_reg(CFG_RICE_PARAM, VALUE_W'(2));
            write_reg(CFG_ENTRY_COUNT, '0);
            repeat (4) send_byte(DATA_W'($urandom_range(0, 255)), 1'b0);
        end else begin
            // final byte ends the stream: an open remainder is padded, then deltas are missing
            write_reg(CFG_RICE_PARAM, VALUE_W'(20));
            repeat (3) send_byte(DATA_W'($urandom_range(0, 255)), 1'b0);
            send_byte(8'h7F, 1'b1);
        end
        // decode is over: these are ignored and must produce nothing
        send_byte(DATA_W'($urandom_range(0, 255)), 1'b0);
        send_byte(DATA_W'($urandom_range(0, 255)), 1'b1);
        wait_drained();

        if (fail_count == 0)
            $display("rice_delta_decoder regression: pass");
        else
            $display("rice_delta_decoder regression: fail");
        $finish;
    end

    // hang guard, well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("rice_delta_decoder regression: fail");
        $finish;
    end

endmodule
